// ===== sv/lfht_pkg.sv =====
`default_nettype none

package lfht_pkg;

   // Table geometry
   localparam int SLOTS       = 1024;
   localparam int HANDLE_BITS = 16;
   localparam int SLOT_W      = $clog2(SLOTS);

   // Each cell holds a power-of-two run of used bits, at most 32
   localparam int CELL_LOW_W  = (SLOT_W > 5) ? 5 : SLOT_W - 1;
   localparam int CELL_BITS   = 2 ** CELL_LOW_W;
   localparam int CELL_ID_W   = SLOT_W - CELL_LOW_W;
   localparam int CELLS       = (SLOTS + CELL_BITS - 1) / CELL_BITS;

   // Slots that come out of reset occupied, each holding its own index
   localparam int PRESET_SLOTS = 3;
   localparam int PRESET_W     = $clog2(PRESET_SLOTS);

   // Word field widths
   localparam int CMD_W        = 2;
   localparam int FH_W         = 16;
   localparam int SLOT_FIELD_W = 10;
   localparam int TARGET_W     = 11;
   localparam int STATUS_W     = 2;

   // Dup target that asks for the lowest free slot
   localparam int TARGET_ANY = -1;

   typedef enum logic [CMD_W-1:0] {
      CMD_ASSIGN = 2'd0,
      CMD_GET    = 2'd1,
      CMD_DUP    = 2'd2,
      CMD_CLOSE  = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK   = 2'd0,
      STATUS_BAD  = 2'd1,
      STATUS_FULL = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_SEARCH = 2'd1,
      ST_DRAIN  = 2'd2
   } state_type;

   // Search token that walks the cell chain
   typedef struct packed {
      logic              valid;
      logic [SLOT_W-1:0] src;
      logic [SLOT_W-1:0] tgt;
      logic              found;
      logic [SLOT_W-1:0] pick;
      logic              src_used;
      logic              tgt_used;
   } token_type;

   // Used-bit update broadcast to every cell
   typedef struct packed {
      logic              set_en;
      logic              clr_en;
      logic [SLOT_W-1:0] addr;
   } update_type;

endpackage

`default_nettype wire

// ===== sv/lfht_cell.sv =====
`default_nettype none

module lfht_cell import lfht_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic [CELL_ID_W-1:0] cell_id,
   input  wire token_type            chain_in,
   input  wire update_type           upd,
   output token_type                 chain_out
);

   logic [CELL_BITS-1:0]  used_ff;
   logic [CELL_BITS-1:0]  used_in;
   logic [CELL_BITS-1:0]  init_used;
   logic [CELL_BITS-1:0]  free_bits;
   logic [CELL_BITS-1:0]  low_free;
   logic [CELL_LOW_W-1:0] low_idx;
   logic                  src_hit;
   logic                  tgt_hit;
   logic                  upd_hit;
   token_type             tok_ff;
   token_type             tok_in;

   // Preset slots start occupied; slots past the table end never read as free
   always_comb begin
      for (int j = 0; j < CELL_BITS; j++) begin
         init_used[j] = (int'({cell_id, CELL_LOW_W'(j)}) < PRESET_SLOTS) ||
                        (int'({cell_id, CELL_LOW_W'(j)}) >= SLOTS);
      end
   end

   // Isolate the lowest free bit and encode its position
   always_comb begin
      free_bits = ~used_ff;
      low_free  = free_bits & (~free_bits + CELL_BITS'(1));
      low_idx   = '0;
      for (int j = 0; j < CELL_BITS; j++) begin
         if (low_free[j]) begin
            low_idx = low_idx | CELL_LOW_W'(j);
         end
      end
   end

   assign src_hit = (chain_in.src[SLOT_W-1:CELL_LOW_W] == cell_id);
   assign tgt_hit = (chain_in.tgt[SLOT_W-1:CELL_LOW_W] == cell_id);
   assign upd_hit = (upd.addr[SLOT_W-1:CELL_LOW_W] == cell_id);

   // Fold this cell's bits into the passing token
   always_comb begin
      tok_in = chain_in;
      if (chain_in.valid) begin
         tok_in.src_used = chain_in.src_used |
                           (src_hit & used_ff[chain_in.src[CELL_LOW_W-1:0]]);
         tok_in.tgt_used = chain_in.tgt_used |
                           (tgt_hit & used_ff[chain_in.tgt[CELL_LOW_W-1:0]]);
         if (!chain_in.found && (|free_bits)) begin
            tok_in.found = 1'b1;
            tok_in.pick  = {cell_id, low_idx};
         end
      end
   end

   // Apply a set or clear that lands in this cell
   always_comb begin
      used_in = used_ff;
      if (upd_hit && upd.set_en) begin
         used_in[upd.addr[CELL_LOW_W-1:0]] = 1'b1;
      end
      if (upd_hit && upd.clr_en) begin
         used_in[upd.addr[CELL_LOW_W-1:0]] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= init_used;
      end else begin
         used_ff <= used_in;
      end
   end

   // Hand the token to the next cell
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff <= tok_in;
      end
   end

   assign chain_out = tok_ff;

endmodule

`default_nettype wire

// ===== sv/lowest_free_handle_table.sv =====
`default_nettype none

// Descriptor table of 1024 slots, each free or holding a 16-bit file handle.
// One word is taken at a time. A search token walks a chain of 32 cells, one
// cell per cycle; each cell owns 32 used bits, notes whether the source and
// target slots are occupied and claims the lowest free slot it sees. After
// the token leaves the last cell the command is committed (used bit and handle
// memory) and the decided word is parked; the result word is loaded once the
// output register is free, and only then is the next word taken. The handle
// memory has one read port, used at acceptance, and one write port, used at
// commit. Slots 0 to 2 come out of reset occupied with handles 0, 1 and 2;
// there is no clearing pass, a word may be presented right after reset.
module lowest_free_handle_table import lfht_pkg::*; (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic [CMD_W-1:0]           req_cmd,
   input  wire logic [FH_W-1:0]            req_file_handle,
   input  wire logic [SLOT_FIELD_W-1:0]    req_slot,
   input  wire logic signed [TARGET_W-1:0] req_target,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic [STATUS_W-1:0]             rsp_status,
   output logic [SLOT_FIELD_W-1:0]         rsp_result_slot,
   output logic [FH_W-1:0]                 rsp_result_handle,
   output logic                            rsp_handle_found
);

   state_type                     state_ff;
   state_type                     state_in;
   logic                          accept;
   logic                          load_rsp;

   cmd_type                       cmd_ff;
   logic [HANDLE_BITS-1:0]        handle_ff;
   logic [SLOT_FIELD_W-1:0]       src_ff;
   logic signed [TARGET_W-1:0]    tgt_ff;
   logic [HANDLE_BITS-1:0]        rd_data_ff;
   logic [PRESET_SLOTS-1:0]       init_live_ff;
   logic [PRESET_SLOTS-1:0]       init_live_in;

   logic [HANDLE_BITS-1:0]        handle_mem [SLOTS];
   logic                          mem_we;
   logic [SLOT_W-1:0]             mem_waddr;
   logic [HANDLE_BITS-1:0]        mem_wdata;

   token_type                     launch_tok;
   token_type                     chain [0:CELLS];
   logic [CELLS-1:0]              chain_valid;
   token_type                     tok_end;
   update_type                    upd;

   logic                          decide;
   logic                          src_bad;
   logic                          tgt_bad;
   logic                          tgt_any;
   logic                          src_preset;
   logic [HANDLE_BITS-1:0]        src_handle;
   status_type                    dec_status;
   logic [SLOT_FIELD_W-1:0]       dec_slot;
   logic [FH_W-1:0]               dec_handle;
   logic                          dec_found;

   status_type                    pend_status_ff;
   logic [SLOT_FIELD_W-1:0]       pend_slot_ff;
   logic [FH_W-1:0]               pend_handle_ff;
   logic                          pend_found_ff;

   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   status_type                    rsp_status_ff;
   logic [SLOT_FIELD_W-1:0]       rsp_slot_ff;
   logic [FH_W-1:0]               rsp_handle_ff;
   logic                          rsp_found_ff;

   assign accept = req_valid && !req_stall;

   // Launch the token straight from the accepted word
   always_comb begin
      launch_tok        = '0;
      launch_tok.valid  = accept;
      launch_tok.src    = SLOT_W'(req_slot);
      launch_tok.tgt    = SLOT_W'(req_target);
   end

   assign chain[0] = launch_tok;

   for (genvar g = 0; g < CELLS; g++) begin : g_cell
      lfht_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cell_id   (CELL_ID_W'(g)),
         .chain_in  (chain[g]),
         .upd       (upd),
         .chain_out (chain[g+1])
      );
      assign chain_valid[g] = chain[g+1].valid;
   end

   assign tok_end = chain[CELLS];

   // Hold the accepted word for the commit
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff    <= cmd_type'(req_cmd);
         handle_ff <= HANDLE_BITS'(req_file_handle);
         src_ff    <= req_slot;
         tgt_ff    <= req_target;
      end
   end

   // Handle memory: read the source at acceptance, write at commit
   always_ff @(posedge clock) begin
      if (mem_we) begin
         handle_mem[mem_waddr] <= mem_wdata;
      end
      if (accept) begin
         rd_data_ff <= handle_mem[SLOT_W'(req_slot)];
      end
   end

   // Track preset slots whose handle has not been overwritten yet
   always_comb begin
      init_live_in = init_live_ff;
      for (int k = 0; k < PRESET_SLOTS; k++) begin
         if (mem_we && (mem_waddr == SLOT_W'(k))) begin
            init_live_in[k] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         init_live_ff <= '1;
      end else begin
         init_live_ff <= init_live_in;
      end
   end

   assign decide     = (state_ff == ST_SEARCH) && tok_end.valid;
   assign src_bad    = int'(src_ff) >= SLOTS;
   assign tgt_bad    = (int'(tgt_ff) < TARGET_ANY) || (int'(tgt_ff) >= SLOTS);
   assign tgt_any    = int'(tgt_ff) == TARGET_ANY;
   assign src_preset = (int'(src_ff) < PRESET_SLOTS) &&
                       init_live_ff[src_ff[PRESET_W-1:0]];
   assign src_handle = src_preset ? HANDLE_BITS'(src_ff) : rd_data_ff;

   // Decide the command once the token has seen every cell
   always_comb begin
      dec_status  = STATUS_OK;
      dec_slot    = '0;
      dec_handle  = '0;
      dec_found   = 1'b0;
      upd.set_en  = 1'b0;
      upd.clr_en  = 1'b0;
      upd.addr    = tok_end.pick;
      mem_we      = 1'b0;
      mem_waddr   = tok_end.pick;
      mem_wdata   = handle_ff;
      unique case (cmd_ff)
         CMD_ASSIGN: begin
            if (!tok_end.found) begin
               dec_status = STATUS_FULL;
            end else begin
               upd.set_en = decide;
               mem_we     = decide;
               dec_slot   = SLOT_FIELD_W'(tok_end.pick);
            end
         end
         CMD_GET: begin
            if (src_bad || !tok_end.src_used) begin
               dec_status = STATUS_BAD;
            end else begin
               dec_handle = FH_W'(src_handle);
               dec_found  = 1'b1;
            end
         end
         CMD_DUP: begin
            mem_wdata = src_handle;
            if (src_bad || tgt_bad || !tok_end.src_used) begin
               dec_status = STATUS_BAD;
            end else if (tgt_any) begin
               if (!tok_end.found) begin
                  dec_status = STATUS_FULL;
               end else begin
                  upd.set_en = decide;
                  mem_we     = decide;
                  dec_slot   = SLOT_FIELD_W'(tok_end.pick);
               end
            end else if (tok_end.tgt_used) begin
               dec_status = STATUS_BAD;
            end else begin
               upd.set_en = decide;
               upd.addr   = tok_end.tgt;
               mem_we     = decide;
               mem_waddr  = tok_end.tgt;
               dec_slot   = SLOT_FIELD_W'(tok_end.tgt);
            end
         end
         CMD_CLOSE: begin
            upd.addr = SLOT_W'(src_ff);
            if (src_bad || !tok_end.src_used) begin
               dec_status = STATUS_BAD;
            end else begin
               upd.clr_en = decide;
            end
         end
         default: begin
            dec_status = STATUS_BAD;
         end
      endcase
   end

   // Park the decided word until the output register is free
   always_ff @(posedge clock) begin
      if (decide) begin
         pend_status_ff <= dec_status;
         pend_slot_ff   <= dec_slot;
         pend_handle_ff <= dec_handle;
         pend_found_ff  <= dec_found;
      end
   end

   // Sequence one word at a time
   always_comb begin
      state_in  = state_ff;
      req_stall = 1'b1;
      load_rsp  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (tok_end.valid) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Output register: load a new word or drop the one taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_status_ff <= pend_status_ff;
         rsp_slot_ff   <= pend_slot_ff;
         rsp_handle_ff <= pend_handle_ff;
         rsp_found_ff  <= pend_found_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_result_slot   = rsp_slot_ff;
   assign rsp_result_handle = rsp_handle_ff;
   assign rsp_handle_found  = rsp_found_ff;

   // At most one token is ever inside the chain
   a_one_token: assert property (@(posedge clock) disable iff (reset)
      $onehot0(chain_valid))
      else $error("more than one search token in the cell chain");

   // A word is taken only with the chain empty
   a_accept_empty: assert property (@(posedge clock) disable iff (reset)
      accept |-> (chain_valid == '0))
      else $error("word accepted while a search is in flight");

   // The token leaves the chain only while a search is pending
   a_end_in_search: assert property (@(posedge clock) disable iff (reset)
      tok_end.valid |-> (state_ff == ST_SEARCH))
      else $error("search token arrived outside a search");

   // Commit writes follow the token's exit and lead to the drain step
   a_commit: assert property (@(posedge clock) disable iff (reset)
      (mem_we || upd.set_en || upd.clr_en) |=> (state_ff == ST_DRAIN))
      else $error("table updated outside a commit");

endmodule

`default_nettype wire
